### rtl/bpj_pkg.sv
// ----------------------------------------------------------------------------
// bpj_pkg
// shared constants, codes and types of the parallel-beam backprojector
// ----------------------------------------------------------------------------
package bpj_pkg;

	localparam int MAX_ANGLES   = 256;
	localparam int MAX_CHANNELS = 512;
	localparam int ANG_W        = $clog2(MAX_ANGLES);
	localparam int CH_W         = $clog2(MAX_CHANNELS);
	localparam int ADDR_W       = ANG_W + CH_W;
	localparam int NA_W         = 9;
	localparam int NS_W         = 10;
	localparam int ACC_W        = 32 + ANG_W + 1;
	localparam int S_W          = 56;
	localparam int CFG_W        = 16;
	localparam int CFG_IDX_W    = 3;

	typedef enum logic [1:0] {
		ACT_SAMPLE = 2'd0,
		ACT_TRIG   = 2'd1,
		ACT_PIXEL  = 2'd2
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ANGLES   = 3'd0,
		CFG_CHANNELS = 3'd1,
		CFG_SCALE_X  = 3'd2,
		CFG_SCALE_Y  = 3'd3,
		CFG_CENTER_X = 3'd4,
		CFG_CENTER_Y = 3'd5,
		CFG_CENTER_S = 3'd6,
		CFG_WEIGHT   = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic               sample_we;
		logic               trig_we;
		logic [ANG_W-1:0]   ang;
		logic [CH_W-1:0]    ch;
		logic [15:0]        sample;
		logic [15:0]        cos_v;
		logic [15:0]        sin_v;
	} wr_t;

	typedef struct packed {
		logic               setup;
		logic               issue;
		logic [ANG_W-1:0]   ang;
	} ctl_t;

endpackage

### rtl/bpj_store.sv
// ----------------------------------------------------------------------------
// bpj_store
// projection memory (two read ports) and trig memory, registered reads
// ----------------------------------------------------------------------------
module bpj_store import bpj_pkg::*; (
	input  logic                     clk,
	input  wr_t                      wr,
	input  logic [ANG_W-1:0]         trig_addr,
	output logic signed [15:0]       cos_rd,
	output logic signed [15:0]       sin_rd,
	input  logic [ADDR_W-1:0]        p_addr0,
	input  logic [ADDR_W-1:0]        p_addr1,
	output logic signed [15:0]       p_rd0,
	output logic signed [15:0]       p_rd1
);

	logic [15:0] proj_mem [MAX_ANGLES*MAX_CHANNELS];
	logic [31:0] trig_mem [MAX_ANGLES];

	always_ff @(posedge clk) begin
		if (wr.sample_we) begin
			proj_mem[{wr.ang, wr.ch}] <= wr.sample;
		end
		p_rd0 <= proj_mem[p_addr0];
		p_rd1 <= proj_mem[p_addr1];
	end

	always_ff @(posedge clk) begin
		if (wr.trig_we) begin
			trig_mem[wr.ang] <= {wr.sin_v, wr.cos_v};
		end
		{sin_rd, cos_rd} <= trig_mem[trig_addr];
	end

endmodule

### rtl/bpj_core.sv
// ----------------------------------------------------------------------------
// bpj_core
// per-angle pipeline: trig read, detector position, range check,
// sample fetch, linear blend and accumulation
// ----------------------------------------------------------------------------
module bpj_core import bpj_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ctl_t                     ctl,
	input  logic [9:0]               px,
	input  logic [9:0]               py,
	input  logic [15:0]              sx,
	input  logic [15:0]              sy,
	input  logic signed [15:0]       cx,
	input  logic signed [15:0]       cy,
	input  logic signed [15:0]       cs,
	input  logic [NS_W-1:0]          ns,
	output logic [ANG_W-1:0]         trig_addr,
	input  logic signed [15:0]       cos_rd,
	input  logic signed [15:0]       sin_rd,
	output logic [ADDR_W-1:0]        p_addr0,
	output logic [ADDR_W-1:0]        p_addr1,
	input  logic signed [15:0]       p_rd0,
	input  logic signed [15:0]       p_rd1,
	output logic signed [ACC_W-1:0]  acc,
	output logic                     busy
);

	logic signed [17:0]       dx, dy;
	logic signed [34:0]       tx_q, ty_q;
	logic                     v_s1, v_s2, v_s3, hit_s4, hit_s5;
	logic [ANG_W-1:0]         ang_s1, ang_s2, ang_s3;
	logic signed [33:0]       pxl_s2, pxh_s2, pyl_s2, pyh_s2;
	logic signed [S_W-1:0]    s_s3, s_sum;
	logic [NS_W+30:0]         lim;
	logic                     hit;
	logic [CH_W-1:0]          i1, i2;
	logic [15:0]              u, u_s4;
	logic signed [33:0]       m1, m2, m1_s5, m2_s5;
	logic signed [ACC_W-1:0]  acc_q;

	assign dx = $signed({3'b000, px, 5'b00000}) - $signed({{2{cx[15]}}, cx});
	assign dy = $signed({{2{cy[15]}}, cy}) - $signed({3'b000, py, 5'b00000});

	always_ff @(posedge clk) begin
		if (ctl.setup) begin
			tx_q <= dx * $signed({1'b0, sx});
			ty_q <= dy * $signed({1'b0, sy});
		end
	end

	assign trig_addr = ctl.ang;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			hit_s4 <= 1'b0;
			hit_s5 <= 1'b0;
		end else begin
			v_s1   <= ctl.issue;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			hit_s4 <= hit;
			hit_s5 <= hit_s4;
		end
	end

	// split products keep each multiplier near 18x16
	always_ff @(posedge clk) begin
		ang_s1 <= ctl.ang;
		ang_s2 <= ang_s1;
		pxl_s2 <= $signed({1'b0, tx_q[16:0]}) * cos_rd;
		pxh_s2 <= $signed(tx_q[34:17]) * cos_rd;
		pyl_s2 <= $signed({1'b0, ty_q[16:0]}) * sin_rd;
		pyh_s2 <= $signed(ty_q[34:17]) * sin_rd;
	end

	assign s_sum = ($signed({{(S_W-34){pxh_s2[33]}}, pxh_s2}) <<< 17)
		+ $signed({{(S_W-34){pxl_s2[33]}}, pxl_s2})
		+ ($signed({{(S_W-34){pyh_s2[33]}}, pyh_s2}) <<< 17)
		+ $signed({{(S_W-34){pyl_s2[33]}}, pyl_s2})
		+ ($signed({{(S_W-16){cs[15]}}, cs}) <<< 26);

	always_ff @(posedge clk) begin
		ang_s3 <= ang_s2;
		s_s3   <= s_sum;
	end

	assign lim = {ns - NS_W'(1), 31'd0};
	assign hit = v_s3 && (ns != '0) && !s_s3[S_W-1]
		&& (s_s3 <= $signed(S_W'(lim)));
	assign i1 = s_s3[31 +: CH_W];
	assign u  = s_s3[30:15];
	assign i2 = (u != 16'd0) ? i1 + CH_W'(1) : i1;
	assign p_addr0 = {ang_s3, i1};
	assign p_addr1 = {ang_s3, i2};

	always_ff @(posedge clk) begin
		u_s4 <= u;
	end

	assign m1 = p_rd0 * $signed({1'b0, 17'(17'h10000 - {1'b0, u_s4})});
	assign m2 = p_rd1 * $signed({2'b00, u_s4});

	always_ff @(posedge clk) begin
		m1_s5 <= m1;
		m2_s5 <= m2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.setup) begin
			acc_q <= '0;
		end else if (hit_s5) begin
			acc_q <= acc_q + $signed({{(ACC_W-34){m1_s5[33]}}, m1_s5})
				+ $signed({{(ACC_W-34){m2_s5[33]}}, m2_s5});
		end
	end

	assign acc  = acc_q;
	assign busy = v_s1 | v_s2 | v_s3 | hit_s4 | hit_s5;

endmodule

### rtl/parallel_beam_backprojection.sv
// ----------------------------------------------------------------------------
// parallel_beam_backprojection
// pixel-driven 2d parallel-beam backprojector
// ----------------------------------------------------------------------------
// Input stream s_*: tuser carries the action. A sample load or a trig load
// writes its memory in the transfer cycle, so loads can follow back to back.
// A pixel transfer starts a reconstruction that issues one angle per cycle
// into a six-stage pipeline (trig read, split products, position sum, range
// check and two-port sample read, blend, accumulate). Once the pipeline has
// drained, the accumulator is weighted in two partial products, rounded and
// saturated, and the result register loads; the next transfer can be taken
// in the cycle after that load.
// s_tready is high only while no pixel is in work.
// Output stream m_*: one transfer per pixel, from an output register; the
// next pixel is computed while a result waits and holds before its final
// load until the register is taken.
// Reset clears control and restores the register defaults; memory contents
// are undefined until loaded. Configuration writes take effect at once.
// ----------------------------------------------------------------------------
module parallel_beam_backprojection import bpj_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// angle_index, channel_index, sample_value, cos_value, sin_value,
	// pixel_x, pixel_y
	input  logic [87:0]          s_tdata,
	// action
	input  logic [1:0]           s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// out_x, out_y, pixel_value
	output logic [55:0]          m_tdata,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SETUP  = 6'b000010,
		ST_RUN    = 6'b000100,
		ST_DRAIN  = 6'b001000,
		ST_SCALE1 = 6'b010000,
		ST_SCALE2 = 6'b100000
	} state_t;

	state_t                 state_q;
	logic [NA_W-1:0]        angles_q, na, ang_q;
	logic [NS_W-1:0]        channels_q, ns;
	logic [15:0]            sx_q, sy_q, w_q;
	logic signed [15:0]     cx_q, cy_q, cs_q;
	logic [9:0]             px_q, py_q;
	logic                   accept;
	action_t                act;
	wr_t                    wr;
	ctl_t                   ctl;
	logic [ANG_W-1:0]       trig_addr;
	logic signed [15:0]     cos_rd, sin_rd, p_rd0, p_rd1;
	logic [ADDR_W-1:0]      p_addr0, p_addr1;
	logic signed [ACC_W-1:0] acc;
	logic                   busy;
	logic [39:0]            lo_q;
	logic signed [33:0]     hi_q;
	logic signed [59:0]     prod, rnd;
	logic signed [31:0]     sat;
	logic                   out_free;
	logic                   load_res;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign act      = action_t'(s_tuser);
	assign na       = (angles_q > NA_W'(MAX_ANGLES)) ? NA_W'(MAX_ANGLES) : angles_q;
	assign ns       = (channels_q > NS_W'(MAX_CHANNELS)) ? NS_W'(MAX_CHANNELS) : channels_q;
	assign out_free = !m_tvalid || m_tready;
	assign load_res = (state_q == ST_SCALE2) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angles_q   <= NA_W'(256);
			channels_q <= NS_W'(512);
			sx_q       <= 16'd4096;
			sy_q       <= 16'd4096;
			cx_q       <= 16'sd16368;
			cy_q       <= 16'sd16368;
			cs_q       <= 16'sd8176;
			w_q        <= 16'd201;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ANGLES:   angles_q   <= cfg_data[NA_W-1:0];
				CFG_CHANNELS: channels_q <= cfg_data[NS_W-1:0];
				CFG_SCALE_X:  sx_q       <= cfg_data;
				CFG_SCALE_Y:  sy_q       <= cfg_data;
				CFG_CENTER_X: cx_q       <= cfg_data;
				CFG_CENTER_Y: cy_q       <= cfg_data;
				CFG_CENTER_S: cs_q       <= cfg_data;
				CFG_WEIGHT:   w_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		wr.sample_we = accept && (act == ACT_SAMPLE);
		wr.trig_we   = accept && (act == ACT_TRIG);
		wr.ang       = s_tdata[7:0];
		wr.ch        = s_tdata[16:8];
		wr.sample    = s_tdata[32:17];
		wr.cos_v     = s_tdata[48:33];
		wr.sin_v     = s_tdata[64:49];
		ctl.setup    = (state_q == ST_SETUP);
		ctl.issue    = (state_q == ST_RUN) && (ang_q < na);
		ctl.ang      = ang_q[ANG_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (accept && (act == ACT_PIXEL)) begin
			px_q <= s_tdata[74:65];
			py_q <= s_tdata[84:75];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ang_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (act == ACT_PIXEL)) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					ang_q   <= '0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (ang_q < na) begin
						ang_q <= ang_q + NA_W'(1);
					end else begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!busy) begin
						state_q <= ST_SCALE1;
					end
				end
				ST_SCALE1: state_q <= ST_SCALE2;
				ST_SCALE2: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	bpj_store u_store (
		.clk       (clk),
		.wr        (wr),
		.trig_addr (trig_addr),
		.cos_rd    (cos_rd),
		.sin_rd    (sin_rd),
		.p_addr0   (p_addr0),
		.p_addr1   (p_addr1),
		.p_rd0     (p_rd0),
		.p_rd1     (p_rd1)
	);

	bpj_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.px        (px_q),
		.py        (py_q),
		.sx        (sx_q),
		.sy        (sy_q),
		.cx        (cx_q),
		.cy        (cy_q),
		.cs        (cs_q),
		.ns        (ns),
		.trig_addr (trig_addr),
		.cos_rd    (cos_rd),
		.sin_rd    (sin_rd),
		.p_addr0   (p_addr0),
		.p_addr1   (p_addr1),
		.p_rd0     (p_rd0),
		.p_rd1     (p_rd1),
		.acc       (acc),
		.busy      (busy)
	);

	// weight product split in two partial products
	always_ff @(posedge clk) begin
		if (state_q == ST_SCALE1) begin
			lo_q <= {16'd0, acc[23:0]} * {24'd0, w_q};
			hi_q <= $signed(acc[ACC_W-1:24]) * $signed({1'b0, w_q});
		end
	end

	assign prod = ($signed({{26{hi_q[33]}}, hi_q}) <<< 24) + $signed({20'd0, lo_q});
	assign rnd  = (prod + 60'sd536870912) >>> 30;
	assign sat  = (rnd > 60'sd2147483647) ? 32'sh7fffffff :
		(rnd < -60'sd2147483648) ? 32'sh80000000 : rnd[31:0];

	// result register loads in scale2 once the previous result is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load_res) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			m_tdata <= {4'd0, sat, py_q, px_q};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !busy)
		else $error("pipeline busy while idle");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (ang_q <= na))
		else $error("angle counter past count");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

endmodule

### tb/sv/tb_parallel_beam_backprojection.sv
// ----------------------------------------------------------------------------
// tb_parallel_beam_backprojection
// self-checking testbench of the parallel-beam backprojector: the part of the
// stores in use is filled first, then a directed table and randomized phases
// of loads and pixels under changing register settings are checked against a
// predictor
// ----------------------------------------------------------------------------
module tb_parallel_beam_backprojection import bpj_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FILL_ANG    = 8;
	localparam int FILL_CH     = 32;
	localparam int PHASE_ITEMS = 65;
	localparam logic [1:0] ACT_NONE = 2'd3;

	typedef struct {
		logic [9:0]  x;
		logic [9:0]  y;
		logic [31:0] value;
	} pixel_res_t;

	typedef enum int {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [1:0]  act;
		logic [7:0]  ang;
		logic [8:0]  ch;
		logic [15:0] smp;
		logic [15:0] cos_v;
		logic [15:0] sin_v;
		logic [9:0]  px;
		logic [9:0]  py;
		cfg_idx_t    idx;
		logic [15:0] cval;
		bit          fixed;
		logic [31:0] fixed_value;
	} row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [87:0]          s_tdata = '0;
	logic [1:0]           s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [55:0]          m_tdata;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	logic signed [15:0] proj_mem [MAX_ANGLES*MAX_CHANNELS];
	logic signed [15:0] cos_mem [MAX_ANGLES];
	logic signed [15:0] sin_mem [MAX_ANGLES];
	logic [8:0]         r_angles = 9'd256;
	logic [9:0]         r_channels = 10'd512;
	logic [15:0]        r_scale_x = 16'd4096;
	logic [15:0]        r_scale_y = 16'd4096;
	logic signed [15:0] r_center_x = 16'sd16368;
	logic signed [15:0] r_center_y = 16'sd16368;
	logic signed [15:0] r_center_s = 16'sd8176;
	logic [15:0]        r_weight = 16'd201;

	pixel_res_t pending_pixels [$];
	row_t       table_rows [$];
	int         errors = 0;
	int         pixels_seen = 0;
	int         loads_sent = 0;
	int         cfg_phases = 0;
	bit         idle_on = 1'b1;

	parallel_beam_backprojection uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	function automatic logic [31:0] backproject(logic [9:0] px, logic [9:0] py);
		longint na, ns, dx, dy, tx, ty, cs, sum, s, r, i1, u, i2, base;
		na = (r_angles > 256) ? 256 : r_angles;
		ns = (r_channels > 512) ? 512 : r_channels;
		dx = longint'(px) * 32 - longint'(r_center_x);
		dy = longint'(r_center_y) - longint'(py) * 32;
		tx = dx * longint'(r_scale_x);
		ty = dy * longint'(r_scale_y);
		cs = longint'(r_center_s) * (64'sd1 <<< 26);
		sum = 0;
		for (longint a = 0; a < na && ns > 0; a++) begin
			s = tx * longint'(cos_mem[a]) + ty * longint'(sin_mem[a]) + cs;
			if (s < 0 || s > ((ns - 1) <<< 31))
				continue;
			i1 = s >>> 31;
			u = (s & 64'h7FFF_FFFF) >>> 15;
			i2 = (u != 0) ? i1 + 1 : i1;
			base = a * MAX_CHANNELS;
			sum += longint'(proj_mem[base + i1]) * (65536 - u)
				+ longint'(proj_mem[base + i2]) * u;
		end
		r = (sum * longint'(r_weight) + (64'sd1 <<< 29)) >>> 30;
		if (r > 64'sd2147483647)
			r = 64'sd2147483647;
		if (r < -64'sd2147483648)
			r = -64'sd2147483648;
		return r[31:0];
	endfunction

	// receiver side stalls
	int rx_burst = 0;
	always @(posedge clk) begin
		if (!idle_on) begin
			m_tready <= 1'b1;
		end else if (rx_burst > 0) begin
			rx_burst <= rx_burst - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			rx_burst <= $urandom_range(0, 8);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// result checking
	always @(posedge clk) begin
		pixel_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			pixels_seen++;
			if (pending_pixels.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected transfer x=%0d y=%0d value=%0d",
						m_tdata[9:0], m_tdata[19:10], $signed(m_tdata[51:20]));
			end else begin
				want = pending_pixels.pop_front();
				if (m_tdata[9:0] !== want.x || m_tdata[19:10] !== want.y
						|| m_tdata[51:20] !== want.value) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected x=%0d y=%0d value=%0d, %s %0d %0d %0d",
							want.x, want.y, $signed(want.value), "got x y value",
							m_tdata[9:0], m_tdata[19:10], $signed(m_tdata[51:20]));
				end
			end
		end
	end

	task automatic gap();
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	task automatic send(row_t r);
		pixel_res_t p;
		s_tvalid <= 1'b1;
		s_tuser <= r.act;
		s_tdata <= {3'b0, r.py, r.px, r.sin_v, r.cos_v, r.smp, r.ch, r.ang};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		case (r.act)
			ACT_SAMPLE: begin
				proj_mem[{r.ang, r.ch}] = r.smp;
				loads_sent++;
			end
			ACT_TRIG: begin
				cos_mem[r.ang] = r.cos_v;
				sin_mem[r.ang] = r.sin_v;
				loads_sent++;
			end
			ACT_PIXEL: begin
				p.x = r.px;
				p.y = r.py;
				p.value = r.fixed ? r.fixed_value : backproject(r.px, r.py);
				pending_pixels.push_back(p);
			end
			default: ;
		endcase
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_ANGLES:   r_angles = v[8:0];
			CFG_CHANNELS: r_channels = v[9:0];
			CFG_SCALE_X:  r_scale_x = v;
			CFG_SCALE_Y:  r_scale_y = v;
			CFG_CENTER_X: r_center_x = v;
			CFG_CENTER_Y: r_center_y = v;
			CFG_CENTER_S: r_center_s = v;
			CFG_WEIGHT:   r_weight = v;
			default: ;
		endcase
	endtask

	function automatic row_t item(logic [1:0] act, logic [7:0] ang, logic [8:0] ch,
			logic [15:0] smp, logic [15:0] c, logic [15:0] sn, logic [9:0] px,
			logic [9:0] py);
		row_t r;
		r.kind = ROW_ITEM; r.act = act; r.ang = ang; r.ch = ch; r.smp = smp;
		r.cos_v = c; r.sin_v = sn; r.px = px; r.py = py;
		r.idx = CFG_ANGLES; r.cval = '0; r.fixed = 1'b0; r.fixed_value = '0;
		return r;
	endfunction

	function automatic row_t pix(logic [9:0] px, logic [9:0] py, bit fixed,
			logic [31:0] v);
		row_t r;
		r = item(ACT_PIXEL, '0, '0, '0, '0, '0, px, py);
		r.fixed = fixed;
		r.fixed_value = v;
		return r;
	endfunction

	function automatic row_t cfg_row(cfg_idx_t idx, logic [15:0] v);
		row_t r;
		r = item('0, '0, '0, '0, '0, '0, '0, '0);
		r.kind = ROW_CFG; r.idx = idx; r.cval = v;
		return r;
	endfunction

	function automatic logic [15:0] rand_trig();
		return 16'($signed($urandom_range(0, 32768)) - 16384);
	endfunction

	function automatic row_t rand_item();
		row_t r;
		int k;
		k = $urandom_range(0, 99);
		r = item(ACT_PIXEL, 8'($urandom), 9'($urandom), 16'($urandom), rand_trig(),
			rand_trig(), 10'($urandom), 10'($urandom));
		if (k < 30)
			r.act = ACT_SAMPLE;
		else if (k < 50)
			r.act = ACT_TRIG;
		else if (k < 53)
			r.act = ACT_NONE;
		else if (k < 85) begin
			r.px = 10'($urandom_range(500, 524));
			r.py = 10'($urandom_range(500, 524));
		end
		return r;
	endfunction

	function automatic logic [15:0] pick(logic [15:0] lo, logic [15:0] hi,
			logic [15:0] mid);
		case ($urandom_range(0, 5))
			0: return lo;
			1: return hi;
			2, 3: return mid;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// fill the angles and channels in use so that every read is defined
		idle_on = 1'b0;
		for (int a = 0; a < FILL_ANG; a++)
			send(item(ACT_TRIG, 8'(a), '0, '0, rand_trig(), rand_trig(), '0, '0));
		for (int a = 0; a < FILL_ANG; a++)
			for (int c = 0; c < FILL_CH; c++)
				send(item(ACT_SAMPLE, 8'(a), 9'(c), 16'($urandom), '0, '0, '0, '0));
		idle_on = 1'b1;

		table_rows.push_back(cfg_row(CFG_ANGLES, 16'(FILL_ANG)));
		table_rows.push_back(cfg_row(CFG_CHANNELS, 16'(FILL_CH)));
		table_rows.push_back(cfg_row(CFG_CENTER_S, 16'd512));
		table_rows.push_back(pix(10'd512, 10'd512, 1'b0, '0));
		table_rows.push_back(cfg_row(CFG_ANGLES, 16'd0));
		table_rows.push_back(pix(10'd0, 10'd0, 1'b1, '0));
		table_rows.push_back(cfg_row(CFG_ANGLES, 16'(FILL_ANG)));
		table_rows.push_back(cfg_row(CFG_WEIGHT, 16'd0));
		table_rows.push_back(pix(10'd1023, 10'd1023, 1'b1, '0));
		table_rows.push_back(cfg_row(CFG_WEIGHT, 16'd201));
		table_rows.push_back(item(ACT_SAMPLE, 8'd0, 9'd16, 16'h8000, '0, '0, '0, '0));
		table_rows.push_back(item(ACT_SAMPLE, 8'd0, 9'd17, 16'h7FFF, '0, '0, '0, '0));
		table_rows.push_back(item(ACT_SAMPLE, 8'd255, 9'd511, 16'h8000, '0, '0, '0, '0));
		table_rows.push_back(item(ACT_TRIG, 8'd1, '0, '0, 16'sd16384, -16'sd16384,
			'0, '0));
		table_rows.push_back(item(ACT_TRIG, 8'd2, '0, '0, -16'sd16384, 16'sd16384,
			'0, '0));
		table_rows.push_back(item(ACT_NONE, 8'hFF, 9'h1FF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			10'h3FF, 10'h3FF));
		table_rows.push_back(pix(10'd511, 10'd511, 1'b0, '0));
		table_rows.push_back(pix(10'd512, 10'd511, 1'b0, '0));
		table_rows.push_back(cfg_row(CFG_CHANNELS, 16'd0));
		table_rows.push_back(pix(10'd511, 10'd511, 1'b1, '0));
		table_rows.push_back(cfg_row(CFG_CHANNELS, 16'd1));
		table_rows.push_back(pix(10'd511, 10'd511, 1'b0, '0));
		// one angle with zero trig: the position is the detector center alone
		table_rows.push_back(cfg_row(CFG_ANGLES, 16'd1));
		table_rows.push_back(item(ACT_TRIG, 8'd0, '0, '0, '0, '0, '0, '0));
		table_rows.push_back(cfg_row(CFG_CHANNELS, 16'd1023));
		table_rows.push_back(cfg_row(CFG_CENTER_S, 16'd16640));
		table_rows.push_back(pix(10'd100, 10'd900, 1'b1, '0));
		table_rows.push_back(cfg_row(CFG_CENTER_S, 16'd640));
		table_rows.push_back(pix(10'd100, 10'd900, 1'b0, '0));
		table_rows.push_back(cfg_row(CFG_CHANNELS, 16'(FILL_CH)));
		table_rows.push_back(cfg_row(CFG_ANGLES, 16'(FILL_ANG)));
		table_rows.push_back(cfg_row(CFG_CENTER_S, 16'd512));
		table_rows.push_back(cfg_row(CFG_WEIGHT, 16'hFFFF));
		table_rows.push_back(pix(10'd511, 10'd511, 1'b0, '0));
		table_rows.push_back(pix(10'd0, 10'd1023, 1'b0, '0));

		foreach (table_rows[i]) begin
			if (table_rows[i].kind == ROW_CFG) begin
				drain();
				write_reg(table_rows[i].idx, table_rows[i].cval);
				cfg_phases++;
			end else begin
				send(table_rows[i]);
				gap();
			end
		end

		for (int ph = 0; ph < 8; ph++) begin
			drain();
			if (ph == 7) begin
				idle_on = 1'b0;
				write_reg(CFG_ANGLES, 16'(FILL_ANG));
				write_reg(CFG_CHANNELS, 16'(FILL_CH));
				write_reg(CFG_SCALE_X, 16'd4096);
				write_reg(CFG_SCALE_Y, 16'd4096);
				write_reg(CFG_CENTER_X, 16'd16368);
				write_reg(CFG_CENTER_Y, 16'd16368);
				write_reg(CFG_CENTER_S, 16'd512);
				write_reg(CFG_WEIGHT, 16'd201);
			end else begin
				write_reg(CFG_ANGLES, 16'($urandom_range(1, FILL_ANG)));
				write_reg(CFG_CHANNELS, 16'($urandom_range(2, FILL_CH)));
				write_reg(CFG_SCALE_X, pick(16'd0, 16'hFFFF, 16'd4096));
				write_reg(CFG_SCALE_Y, pick(16'd0, 16'hFFFF, 16'd4096));
				write_reg(CFG_CENTER_X, pick(16'h8000, 16'h7FFF, 16'd16368));
				write_reg(CFG_CENTER_Y, pick(16'h8000, 16'h7FFF, 16'd16368));
				write_reg(CFG_CENTER_S, pick(16'h8000, 16'h7FFF,
					16'($urandom_range(0, FILL_CH * 32))));
				write_reg(CFG_WEIGHT, pick(16'd0, 16'hFFFF, 16'd201));
			end
			cfg_phases++;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				send(rand_item());
				gap();
			end
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (pending_pixels.size() != 0)
			errors++;
		$display("checked %0d pixels after %0d loads over %0d register settings",
			pixels_seen, loads_sent, cfg_phases);
		$display("%0d mismatches", errors);
		if (errors == 0)
			$display("[parallel_beam_backprojection] OK");
		else
			$display("[parallel_beam_backprojection] ERROR");
		$finish;
	end

	initial begin
		#2ms;
		$display("[parallel_beam_backprojection] ERROR");
		$finish;
	end

endmodule

### sim.f
rtl/bpj_pkg.sv
rtl/bpj_store.sv
rtl/bpj_core.sv
rtl/parallel_beam_backprojection.sv
tb/sv/tb_parallel_beam_backprojection.sv
